// ===== sv/disparity_to_point_reprojection_macros.svh =====
// Assertion macros for the disparity to point reprojection block
`ifndef DISPARITY_TO_POINT_REPROJECTION_MACROS_SVH
`define DISPARITY_TO_POINT_REPROJECTION_MACROS_SVH

// check a condition in the same cycle as its trigger
`define DTP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// check a condition in the cycle after its trigger
`define DTP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/dtp_pkg.sv =====
// Shared types and constants of the disparity to point reprojection block
package dtp_pkg;

  localparam int REG_W     = 20;
  localparam int MAXD_W    = 9;
  localparam int DISP_W    = 16;
  localparam int DPOS_W    = 15;
  localparam int GRAY_W    = 8;
  localparam int XY_W      = 48;
  localparam int Z_W       = 32;
  localparam int Q_BITS    = 8;
  localparam int DEN_W     = REG_W + DPOS_W;
  localparam int CFG_IDX_W = 3;
  localparam int DIV_LANES = 3;
  localparam int LANE_X    = 0;
  localparam int LANE_Y    = 1;
  localparam int LANE_Z    = 2;

  localparam logic [REG_W-1:0]  FOCAL_X_RST  = 20'd184027;
  localparam logic [REG_W-1:0]  FOCAL_Y_RST  = 20'd184027;
  localparam logic [REG_W-1:0]  CENTER_X_RST = 20'd155441;
  localparam logic [REG_W-1:0]  CENTER_Y_RST = 20'd47415;
  localparam logic [REG_W-1:0]  FB_RST       = 20'd105447;
  localparam logic [MAXD_W-1:0] MAXD_RST     = 9'd96;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FOCAL_X,
    CFG_FOCAL_Y,
    CFG_CENTER_X,
    CFG_CENTER_Y,
    CFG_FOCAL_BASELINE,
    CFG_MAX_DISPARITY
  } cfg_idx_t;

  typedef struct packed {
    logic [GRAY_W-1:0] gray;
    logic              neg_x;
    logic              neg_y;
  } dtp_tag_t;

endpackage

// ===== sv/dtp_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, several lanes in lockstep
module dtp_div #(
  parameter int NW = 53
) (
  input  logic                                                clk,
  input  logic                                                rst_n,
  input  logic                                                en,
  input  logic                                                in_valid,
  input  logic [dtp_pkg::DIV_LANES-1:0][NW-1:0]               in_num,
  input  logic [dtp_pkg::DIV_LANES-1:0][dtp_pkg::DEN_W-1:0]   in_den,
  input  dtp_pkg::dtp_tag_t                                   in_tag,
  output logic                                                out_valid,
  output logic [dtp_pkg::DIV_LANES-1:0][NW-1:0]               out_quo,
  output dtp_pkg::dtp_tag_t                                   out_tag
);

  localparam int L  = dtp_pkg::DIV_LANES;
  localparam int DW = dtp_pkg::DEN_W;

  logic [NW-1:0] v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[NW-2:0], in_valid};
    end
  end

  for (genvar g = 0; g < NW; g++) begin : g_stage
    logic [L-1:0][NW-1:0] src_nq;
    logic [L-1:0][DW-1:0] src_rem;
    logic [L-1:0][DW-1:0] src_den;
    dtp_pkg::dtp_tag_t    src_tag;
    logic [L-1:0][NW-1:0] nq_nxt;
    logic [L-1:0][DW-1:0] rem_nxt;
    logic [L-1:0][NW-1:0] nq_r;
    logic [L-1:0][DW-1:0] rem_r;
    logic [L-1:0][DW-1:0] den_r;
    dtp_pkg::dtp_tag_t    tag_r;

    if (g == 0) begin : g_first
      assign src_nq  = in_num;
      assign src_rem = '0;
      assign src_den = in_den;
      assign src_tag = in_tag;
    end else begin : g_rest
      assign src_nq  = g_stage[g-1].nq_r;
      assign src_rem = g_stage[g-1].rem_r;
      assign src_den = g_stage[g-1].den_r;
      assign src_tag = g_stage[g-1].tag_r;
    end

    always_comb begin
      logic [DW:0] trial;
      logic        ge;
      for (int l = 0; l < L; l++) begin
        trial = {src_rem[l], src_nq[l][NW-1]};
        ge    = trial >= {1'b0, src_den[l]};
        rem_nxt[l] = ge ? DW'(trial - {1'b0, src_den[l]}) : DW'(trial);
        nq_nxt[l]  = {src_nq[l][NW-2:0], ge};
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        nq_r  <= nq_nxt;
        rem_r <= rem_nxt;
        den_r <= src_den;
        tag_r <= src_tag;
      end
    end
  end

  assign out_valid = v_r[NW-1];
  assign out_quo   = g_stage[NW-1].nq_r;
  assign out_tag   = g_stage[NW-1].tag_r;

endmodule

// ===== sv/disparity_to_point_reprojection.sv =====
// Pipeline: three front stages, one divider stage per quotient bit and the output register,
// the first stage loading at the accepting edge. Throughput: one transaction per cycle while
// in_ready is high, the divider being fully pipelined; a two-entry output buffer takes results
// while the consumer stalls, and the whole pipeline halts while the skid entry is full.
// Reset (rst_n low, synchronous) empties the pipeline and loads the register defaults.
module disparity_to_point_reprojection #(
  parameter int COORD_BITS     = 12,
  parameter int DISP_FRAC_BITS = 4
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     cfg_wr_en,
  input  logic [dtp_pkg::CFG_IDX_W-1:0]            cfg_index,
  input  logic [dtp_pkg::REG_W-1:0]                cfg_wdata,
  input  logic                                     in_valid,
  output logic                                     in_ready,
  input  logic [COORD_BITS-1:0]                    in_column,
  input  logic [COORD_BITS-1:0]                    in_row,
  input  logic signed [dtp_pkg::DISP_W-1:0]        in_disparity_raw,
  input  logic [dtp_pkg::GRAY_W-1:0]               in_intensity,
  output logic                                     out_valid,
  input  logic                                     out_ready,
  output logic signed [dtp_pkg::XY_W-1:0]          out_point_x,
  output logic signed [dtp_pkg::XY_W-1:0]          out_point_y,
  output logic [dtp_pkg::Z_W-1:0]                  out_point_z,
  output logic [dtp_pkg::GRAY_W-1:0]               out_point_gray
);

  `include "disparity_to_point_reprojection_macros.svh"

  localparam int RW      = dtp_pkg::REG_W;
  localparam int CW      = COORD_BITS + dtp_pkg::Q_BITS;
  localparam int MAGW    = (CW > RW) ? CW : RW;
  localparam int PROD_W  = MAGW + RW;
  localparam int SH      = DISP_FRAC_BITS + dtp_pkg::Q_BITS;
  localparam int NW      = PROD_W + SH + 1;
  localparam int DW      = dtp_pkg::DEN_W;
  localparam int PW      = dtp_pkg::DPOS_W;
  localparam int BOUND_W = dtp_pkg::MAXD_W + DISP_FRAC_BITS;
  localparam int XW      = dtp_pkg::XY_W;
  localparam int ZW      = dtp_pkg::Z_W;

  localparam logic [NW-1:0] XY_NEG_MAG = NW'(1) << (XW - 1);
  localparam logic [NW-1:0] XY_POS_MAX = XY_NEG_MAG - NW'(1);
  localparam logic [NW-1:0] Z_MAX      = (NW'(1) << ZW) - NW'(1);

  // configuration registers
  logic [RW-1:0]                  focal_x_r, focal_y_r, center_x_r, center_y_r, fb_r;
  logic [dtp_pkg::MAXD_W-1:0]     maxd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      focal_x_r  <= dtp_pkg::FOCAL_X_RST;
      focal_y_r  <= dtp_pkg::FOCAL_Y_RST;
      center_x_r <= dtp_pkg::CENTER_X_RST;
      center_y_r <= dtp_pkg::CENTER_Y_RST;
      fb_r       <= dtp_pkg::FB_RST;
      maxd_r     <= dtp_pkg::MAXD_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        dtp_pkg::CFG_FOCAL_X:        focal_x_r  <= cfg_wdata;
        dtp_pkg::CFG_FOCAL_Y:        focal_y_r  <= cfg_wdata;
        dtp_pkg::CFG_CENTER_X:       center_x_r <= cfg_wdata;
        dtp_pkg::CFG_CENTER_Y:       center_y_r <= cfg_wdata;
        dtp_pkg::CFG_FOCAL_BASELINE: fb_r       <= cfg_wdata;
        dtp_pkg::CFG_MAX_DISPARITY:  maxd_r     <= cfg_wdata[dtp_pkg::MAXD_W-1:0];
        default: ;
      endcase
    end
  end

  logic en;
  logic sv_r, ov_r;
  logic in_fire;

  assign en       = !sv_r;
  assign in_ready = en;
  assign in_fire  = in_valid && in_ready;

  // stage 1: range check, center offsets
  logic [BOUND_W-1:0] bound;
  logic               keep;
  logic [MAGW-1:0]    cx, cy, cenx, ceny;
  logic               negx_nxt, negy_nxt;
  logic [MAGW-1:0]    magx_nxt, magy_nxt;

  always_comb begin
    bound    = BOUND_W'(maxd_r) << DISP_FRAC_BITS;
    keep     = !in_disparity_raw[dtp_pkg::DISP_W-1] && (in_disparity_raw != '0) &&
               (32'(in_disparity_raw[PW-1:0]) < 32'(bound));
    cx       = MAGW'(in_column) << dtp_pkg::Q_BITS;
    cy       = MAGW'(in_row) << dtp_pkg::Q_BITS;
    cenx     = MAGW'(center_x_r);
    ceny     = MAGW'(center_y_r);
    negx_nxt = cx < cenx;
    negy_nxt = cy < ceny;
    magx_nxt = negx_nxt ? cenx - cx : cx - cenx;
    magy_nxt = negy_nxt ? ceny - cy : cy - ceny;
  end

  logic                       v1_r;
  logic [MAGW-1:0]            magx1_r, magy1_r;
  logic [PW-1:0]              d1_r;
  logic [RW-1:0]              fx1_r, fy1_r;
  dtp_pkg::dtp_tag_t          tag1_r;

  // stage 2: products
  logic                       v2_r;
  logic [PROD_W-1:0]          px2_r, py2_r;
  logic [DW-1:0]              dx2_r, dy2_r;
  logic [PW-1:0]              d2_r;
  dtp_pkg::dtp_tag_t          tag2_r;

  // stage 3: rounded numerators into the divider
  logic                                          v3_r;
  logic [dtp_pkg::DIV_LANES-1:0][NW-1:0]         num3_r;
  logic [dtp_pkg::DIV_LANES-1:0][DW-1:0]         den3_r;
  dtp_pkg::dtp_tag_t                             tag3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_fire && keep;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      magx1_r      <= magx_nxt;
      magy1_r      <= magy_nxt;
      d1_r         <= in_disparity_raw[PW-1:0];
      fx1_r        <= (focal_x_r == '0) ? RW'(1) : focal_x_r;
      fy1_r        <= (focal_y_r == '0) ? RW'(1) : focal_y_r;
      tag1_r.gray  <= in_intensity;
      tag1_r.neg_x <= negx_nxt;
      tag1_r.neg_y <= negy_nxt;

      px2_r  <= PROD_W'(magx1_r) * PROD_W'(fb_r);
      py2_r  <= PROD_W'(magy1_r) * PROD_W'(fb_r);
      dx2_r  <= DW'(fx1_r) * DW'(d1_r);
      dy2_r  <= DW'(fy1_r) * DW'(d1_r);
      d2_r   <= d1_r;
      tag2_r <= tag1_r;

      num3_r[dtp_pkg::LANE_X] <= (NW'(px2_r) << SH) + NW'(dx2_r >> 1);
      num3_r[dtp_pkg::LANE_Y] <= (NW'(py2_r) << SH) + NW'(dy2_r >> 1);
      num3_r[dtp_pkg::LANE_Z] <= (NW'(fb_r) << SH) + NW'(d2_r >> 1);
      den3_r[dtp_pkg::LANE_X] <= dx2_r;
      den3_r[dtp_pkg::LANE_Y] <= dy2_r;
      den3_r[dtp_pkg::LANE_Z] <= DW'(d2_r);
      tag3_r <= tag2_r;
    end
  end

  logic                                   pv;
  logic [dtp_pkg::DIV_LANES-1:0][NW-1:0]  quo;
  dtp_pkg::dtp_tag_t                      ptag;

  dtp_div #(.NW(NW)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v3_r),
    .in_num    (num3_r),
    .in_den    (den3_r),
    .in_tag    (tag3_r),
    .out_valid (pv),
    .out_quo   (quo),
    .out_tag   (ptag)
  );

  // saturate
  logic [NW-1:0]  clip_x, clip_y;
  logic [XW-1:0]  px, py;
  logic [ZW-1:0]  pz;

  always_comb begin
    if (ptag.neg_x) begin
      clip_x = (quo[dtp_pkg::LANE_X] > XY_NEG_MAG) ? XY_NEG_MAG : quo[dtp_pkg::LANE_X];
      px     = XW'(~clip_x + NW'(1));
    end else begin
      clip_x = (quo[dtp_pkg::LANE_X] > XY_POS_MAX) ? XY_POS_MAX : quo[dtp_pkg::LANE_X];
      px     = XW'(clip_x);
    end
    if (ptag.neg_y) begin
      clip_y = (quo[dtp_pkg::LANE_Y] > XY_NEG_MAG) ? XY_NEG_MAG : quo[dtp_pkg::LANE_Y];
      py     = XW'(~clip_y + NW'(1));
    end else begin
      clip_y = (quo[dtp_pkg::LANE_Y] > XY_POS_MAX) ? XY_POS_MAX : quo[dtp_pkg::LANE_Y];
      py     = XW'(clip_y);
    end
    pz = (quo[dtp_pkg::LANE_Z] > Z_MAX) ? '1 : ZW'(quo[dtp_pkg::LANE_Z]);
  end

  // output register and skid entry
  logic [XW-1:0]              ox_r, oy_r, sx_r, sy_r;
  logic [ZW-1:0]              oz_r, sz_r;
  logic [dtp_pkg::GRAY_W-1:0] og_r, sg_r;
  logic                       out_fire;

  assign out_fire = ov_r && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
      sv_r <= 1'b0;
    end else begin
      priority if (sv_r) begin
        if (out_ready) begin
          sv_r <= 1'b0;
        end
      end else if (!ov_r || out_ready) begin
        ov_r <= pv;
      end else begin
        if (pv) begin
          sv_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    priority if (sv_r) begin
      if (out_ready) begin
        ox_r <= sx_r;
        oy_r <= sy_r;
        oz_r <= sz_r;
        og_r <= sg_r;
      end
    end else if (!ov_r || out_ready) begin
      ox_r <= px;
      oy_r <= py;
      oz_r <= pz;
      og_r <= ptag.gray;
    end else begin
      sx_r <= px;
      sy_r <= py;
      sz_r <= pz;
      sg_r <= ptag.gray;
    end
  end

  assign out_valid      = ov_r;
  assign out_point_x    = ox_r;
  assign out_point_y    = oy_r;
  assign out_point_z    = oz_r;
  assign out_point_gray = og_r;

  `DTP_ASSERT_NOW(a_skid_behind_out, sv_r, ov_r, "skid entry held without output entry")
  `DTP_ASSERT_NEXT(a_drop_negative, in_fire && in_disparity_raw[dtp_pkg::DISP_W-1], !v1_r,
    "negative disparity entered the pipeline")
  `DTP_ASSERT_NEXT(a_skid_refill, sv_r && out_fire, ov_r && !sv_r,
    "skid entry lost when output drained")
  `DTP_ASSERT_NEXT(a_skid_hold, sv_r && !out_ready, sv_r && ov_r,
    "skid entry dropped during stall")

endmodule
